// File: rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that holds during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cbnc_pkg.sv
// Types and constants of the complex biquad notch cascade.
`default_nettype none
package cbnc_pkg;

   localparam int COEF_W    = 32;
   localparam int FRAC_BITS = 30;
   localparam int CSR_IDX_W = 3;
   localparam int HIST_TAPS = 4;

   // positions inside one section's history row
   localparam int HIST_X1 = 0;
   localparam int HIST_X2 = 1;
   localparam int HIST_Y1 = 2;
   localparam int HIST_Y2 = 3;

   localparam logic signed [COEF_W-1:0] RESET_B0 = 32'sd1065374222;
   localparam logic signed [COEF_W-1:0] RESET_B1 = -32'sd2130222714;
   localparam logic signed [COEF_W-1:0] RESET_B2 = 32'sd1065374222;
   localparam logic signed [COEF_W-1:0] RESET_A1 = 32'sd2130222714;
   localparam logic signed [COEF_W-1:0] RESET_A2 = -32'sd1057006622;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOTCH_ENABLE = 3'd0,
      CSR_NUM_COEF_0   = 3'd1,
      CSR_NUM_COEF_1   = 3'd2,
      CSR_NUM_COEF_2   = 3'd3,
      CSR_FB_COEF_1    = 3'd4,
      CSR_FB_COEF_2    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      TAP_X0,
      TAP_X1,
      TAP_X2,
      TAP_Y1,
      TAP_Y2
   } tap_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                     notch_enable;
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } cfg_type;

   typedef struct packed {
      logic acc_clr;
      logic acc_add;
   } mac_ctrl_type;

endpackage
`default_nettype wire

// File: rtl/cbnc_csr.sv
// Configuration registers: notch enable and the five biquad coefficients.
`default_nettype none
module cbnc_csr (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cbnc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [cbnc_pkg::COEF_W-1:0]            csr_data,
   output cbnc_pkg::cfg_type                           cfg
);
   import cbnc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NOTCH_ENABLE: cfg_in.notch_enable = csr_data[0];
            CSR_NUM_COEF_0:   cfg_in.b0 = $signed(csr_data);
            CSR_NUM_COEF_1:   cfg_in.b1 = $signed(csr_data);
            CSR_NUM_COEF_2:   cfg_in.b2 = $signed(csr_data);
            CSR_FB_COEF_1:    cfg_in.a1 = $signed(csr_data);
            CSR_FB_COEF_2:    cfg_in.a2 = $signed(csr_data);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.notch_enable <= 1'b0;
         cfg_ff.b0 <= RESET_B0;
         cfg_ff.b1 <= RESET_B1;
         cfg_ff.b2 <= RESET_B2;
         cfg_ff.a1 <= RESET_A1;
         cfg_ff.a2 <= RESET_A2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/cbnc_mac.sv
// Shared multiply-accumulate unit with Q2.30 rounding and output saturation.
`default_nettype none
module cbnc_mac #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                   clock,
   input  wire cbnc_pkg::mac_ctrl_type                 ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0]          operand,
   input  wire logic signed [cbnc_pkg::COEF_W-1:0]     coef,
   output logic signed [SAMPLE_BITS-1:0]               result
);
   import cbnc_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_W;
   localparam int ACC_W  = PROD_W + 3;
   localparam int RND_W  = ACC_W + 1;
   localparam int QUO_W  = RND_W - FRAC_BITS;
   localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [RND_W-1:0]  rnd;
   logic signed [QUO_W-1:0]  quot;
   logic [QUO_W-SAMPLE_BITS:0] quot_hi;

   assign prod_in  = operand * coef;
   assign acc_base = ctrl.acc_clr ? '0 : acc_ff;
   assign acc_in   = acc_base + (ctrl.acc_add ? ACC_W'(prod_ff) : ACC_W'(0));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, then clamp to the sample range
   assign rnd     = RND_W'(acc_ff) + ROUND_BIAS;
   assign quot    = $signed(rnd[RND_W-1:FRAC_BITS]);
   assign quot_hi = quot[QUO_W-1:SAMPLE_BITS-1];

   always_comb begin
      if (&quot_hi || ~|quot_hi) begin
         result = quot[SAMPLE_BITS-1:0];
      end else if (quot[QUO_W-1]) begin
         result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

endmodule
`default_nettype wire

// File: rtl/complex_biquad_notch_cascade.sv
// Top level: sequencer, section history and result register of the notch cascade.
//
// Each request carries one complex sample. With notch_enable set it runs through
// SECTIONS biquad sections, real part then imaginary part of each section, all on
// one shared 24x32 multiply-accumulate unit: every section and part runs the
// states MAC (five multiplies), DRAIN (fold in the product register) and ROUND
// (round, saturate and update history). A new request is stalled until the last
// part is done and its result is loaded; with notch_enable clear the sample is
// passed through. The result sits in an output register, so the next request is
// taken while the previous result waits.
// The configuration port is always ready; write it only while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module complex_biquad_notch_cascade #(
   parameter int SECTIONS    = 3,
   parameter int SAMPLE_BITS = 24
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample_re,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample_im,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]            rsp_out_re,
   output logic signed [SAMPLE_BITS-1:0]            rsp_out_im,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cbnc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [cbnc_pkg::COEF_W-1:0]         csr_data
);
   import cbnc_pkg::*;

   localparam int HIST_N = 2 * SECTIONS;
   localparam int SP_W   = $clog2(HIST_N);
   localparam logic [SP_W-1:0] LAST_SP = SP_W'(HIST_N - 1);

   cfg_type      cfg;
   mac_ctrl_type ctrl;
   state_type    state_ff, state_in;
   tap_type      tap_ff, tap_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic         part;
   logic         take;
   logic         hist_we;
   logic         load_rsp;

   logic signed [SAMPLE_BITS-1:0] cur_ff [2];
   logic signed [SAMPLE_BITS-1:0] hist_ff [HIST_N][HIST_TAPS];
   logic signed [SAMPLE_BITS-1:0] operand;
   logic signed [COEF_W-1:0]      coef;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_re_ff, rsp_im_ff;

   cbnc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cbnc_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
      .clock   (clock),
      .ctrl    (ctrl),
      .operand (operand),
      .coef    (coef),
      .result  (mac_result)
   );

   assign part = sp_ff[0];

   always_comb begin
      case (tap_ff)
         TAP_X0: begin
            operand = cur_ff[part];
            coef    = cfg.b0;
         end
         TAP_X1: begin
            operand = hist_ff[sp_ff][HIST_X1];
            coef    = cfg.b1;
         end
         TAP_X2: begin
            operand = hist_ff[sp_ff][HIST_X2];
            coef    = cfg.b2;
         end
         TAP_Y1: begin
            operand = hist_ff[sp_ff][HIST_Y1];
            coef    = cfg.a1;
         end
         TAP_Y2: begin
            operand = hist_ff[sp_ff][HIST_Y2];
            coef    = cfg.a2;
         end
         default: begin
            operand = cur_ff[part];
            coef    = cfg.b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         tap_ff   <= TAP_X0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         tap_ff   <= tap_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sp_in    = sp_ff;
      tap_in   = tap_ff;
      ctrl     = '0;
      take     = 1'b0;
      hist_we  = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               take     = 1'b1;
               sp_in    = '0;
               tap_in   = TAP_X0;
               state_in = cfg.notch_enable ? ST_MAC : ST_DONE;
            end
         end
         ST_MAC: begin
            ctrl.acc_clr = (tap_ff == TAP_X0);
            ctrl.acc_add = (tap_ff != TAP_X0);
            case (tap_ff)
               TAP_X0:  tap_in = TAP_X1;
               TAP_X1:  tap_in = TAP_X2;
               TAP_X2:  tap_in = TAP_Y1;
               TAP_Y1:  tap_in = TAP_Y2;
               default: begin
                  tap_in   = TAP_X0;
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            // fold in the last product still in the multiplier register
            ctrl.acc_add = 1'b1;
            state_in     = ST_ROUND;
         end
         ST_ROUND: begin
            hist_we = 1'b1;
            if (sp_ff == LAST_SP) begin
               state_in = ST_DONE;
            end else begin
               sp_in    = sp_ff + 1'b1;
               tap_in   = TAP_X0;
               state_in = ST_MAC;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff[0] <= req_sample_re;
         cur_ff[1] <= req_sample_im;
      end else if (hist_we) begin
         cur_ff[part] <= mac_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_N; i++) begin
            for (int j = 0; j < HIST_TAPS; j++) begin
               hist_ff[i][j] <= '0;
            end
         end
      end else if (hist_we) begin
         hist_ff[sp_ff][HIST_X2] <= hist_ff[sp_ff][HIST_X1];
         hist_ff[sp_ff][HIST_X1] <= cur_ff[part];
         hist_ff[sp_ff][HIST_Y2] <= hist_ff[sp_ff][HIST_Y1];
         hist_ff[sp_ff][HIST_Y1] <= mac_result;
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_re_ff <= cur_ff[0];
         rsp_im_ff <= cur_ff[1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_re = rsp_re_ff;
   assign rsp_out_im = rsp_im_ff;

   `ASSERT_CLK_RST(a_busy_after_req, clock, reset, (req_valid && !req_stall) |=> req_stall, "request taken but block not busy")
   `ASSERT_CLK_RST(a_done_frees, clock, reset, (state_ff == ST_DONE && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && !req_stall), "finished result not delivered")
   `ASSERT_CLK_RST(a_rsp_from_done, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ST_DONE), "result appeared without finishing")

endmodule
`default_nettype wire
